// File: hdl/checksum_trailer_frame_checker_assert.svh
// Assertion macros used by the checksum trailer frame checker back end.
`ifndef CHECKSUM_TRAILER_FRAME_CHECKER_ASSERT_SVH
`define CHECKSUM_TRAILER_FRAME_CHECKER_ASSERT_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define CTFC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clk edge outside reset.
`define CTFC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/ctfc_pkg.sv
// Types and constants shared by the checksum trailer frame checker modules.
`default_nettype none

package ctfc_pkg;

    // Parser phases
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_LENGTH  = 2'd2,
        PH_DIGITS  = 2'd3
    } phase_t;

    // Result status codes
    localparam logic [1:0] STATUS_MATCH    = 2'd0;
    localparam logic [1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [1:0] STATUS_SHORT    = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_OPEN_MARK  = 2'd0;
    localparam logic [1:0] REG_CLOSE_MARK = 2'd1;
    localparam logic [1:0] REG_END_MARK   = 2'd2;

    // Mark reset values: '(' ')' '*'
    localparam logic [7:0] OPEN_MARK_RST  = 8'h28;
    localparam logic [7:0] CLOSE_MARK_RST = 8'h29;
    localparam logic [7:0] END_MARK_RST   = 8'h2A;

    // Decimal digit range
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_NINE = 8'h39;

    // Saturation limits
    localparam logic [23:0] SUM_MAX   = 24'hFF_FFFF;
    localparam logic [29:0] VALUE_MAX = 30'd999999999;
    localparam logic [3:0]  LEN_MAX   = 4'd15;

    // One classified byte, as queued between front and back
    typedef struct packed {
        logic       start;
        logic [7:0] data;
        logic       is_digit;
        logic [3:0] digit;
        logic       hit_open;
        logic       hit_close;
        logic       hit_end;
    } item_t;

endpackage

`default_nettype wire

// File: hdl/checksum_trailer_frame_checker.sv
// Top level of the checksum trailer frame checker.
`default_nettype none

// Checks byte frames of the form: leading byte (s_tuser high), payload bytes,
// open mark, length digits, close mark, checksum digits, end mark. The payload
// is summed with saturation at 24 bits; the length is the saturated sum of the
// length digit values; the first that-many checksum digits form a decimal value
// that saturates at 999999999. At the end mark one result transaction carries
// status 0 (match), 1 (mismatch) or 2 (fewer digits than the length) with both
// sums. The block takes one byte per clock while the queue has room: the parser
// does one add or one times-ten step per byte, and a QUEUE_DEPTH-entry queue
// parts the byte intake from the parser so either side can stall alone. The
// result is registered onto m_tvalid when the parser takes its end mark, and the
// input keeps flowing while it waits until the next end mark reaches the parser.
// Mark registers are written through the cfg channel (index 0 open, 1 close,
// 2 end) and reset to '(' ')' '*'.
module checksum_trailer_frame_checker
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    // byte input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] frame_start
    // result output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata    // [1:0] status, [25:2] computed_sum,
                                        // [55:26] received_sum
);

    ctfc_pkg::item_t front_item;
    ctfc_pkg::item_t queue_item;
    logic            queue_valid, queue_ready;
    logic [1:0]      res_status;
    logic [23:0]     res_computed_sum;
    logic [29:0]     res_received_sum;

    ctfc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .data_byte   (s_tdata),
        .frame_start (s_tuser),
        .item        (front_item)
    );

    ctfc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_item   (queue_item)
    );

    ctfc_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (queue_valid),
        .item_ready       (queue_ready),
        .item             (queue_item),
        .res_valid        (m_tvalid),
        .res_ready        (m_tready),
        .res_status       (res_status),
        .res_computed_sum (res_computed_sum),
        .res_received_sum (res_received_sum)
    );

    assign m_tdata = {res_received_sum, res_computed_sum, res_status};

endmodule

`default_nettype wire

// File: hdl/ctfc_front.sv
// Front end: mark registers and byte classification.
`default_nettype none

module ctfc_front
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    // configuration write channel
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [1:0]      cfg_index,
    input  wire logic [7:0]      cfg_data,
    // incoming byte
    input  wire logic [7:0]      data_byte,
    input  wire logic            frame_start,
    output ctfc_pkg::item_t      item
);

    logic [7:0] open_mark_reg,  open_mark_next;
    logic [7:0] close_mark_reg, close_mark_next;
    logic [7:0] end_mark_reg,   end_mark_next;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    // register write decode
    always_comb
    begin
        open_mark_next  = open_mark_reg;
        close_mark_next = close_mark_reg;
        end_mark_next   = end_mark_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                ctfc_pkg::REG_OPEN_MARK:  open_mark_next  = cfg_data;
                ctfc_pkg::REG_CLOSE_MARK: close_mark_next = cfg_data;
                ctfc_pkg::REG_END_MARK:   end_mark_next   = cfg_data;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_mark_reg  <= ctfc_pkg::OPEN_MARK_RST;
            close_mark_reg <= ctfc_pkg::CLOSE_MARK_RST;
            end_mark_reg   <= ctfc_pkg::END_MARK_RST;
        end
        else
        begin
            open_mark_reg  <= open_mark_next;
            close_mark_reg <= close_mark_next;
            end_mark_reg   <= end_mark_next;
        end
    end

    // classify: digit value and mark hits; the back picks by phase
    always_comb
    begin
        item.start     = frame_start;
        item.data      = data_byte;
        item.is_digit  = data_byte inside {[ctfc_pkg::DIGIT_ZERO:ctfc_pkg::DIGIT_NINE]};
        item.digit     = item.is_digit ? 4'(data_byte - ctfc_pkg::DIGIT_ZERO) : 4'd0;
        item.hit_open  = (data_byte == open_mark_reg);
        item.hit_close = (data_byte == close_mark_reg);
        item.hit_end   = (data_byte == end_mark_reg);
    end

endmodule

`default_nettype wire

// File: hdl/ctfc_queue.sv
// Short FIFO of classified bytes between front and back.
`default_nettype none

module ctfc_queue
#(
    parameter int DEPTH = 2
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire ctfc_pkg::item_t  push_item,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output ctfc_pkg::item_t       pop_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    ctfc_pkg::item_t entries [DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entries[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

// File: hdl/ctfc_back.sv
// Back end: frame parser, checksum accumulators and result register.
`default_nettype none

`include "checksum_trailer_frame_checker_assert.svh"

module ctfc_back
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire ctfc_pkg::item_t  item,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output logic [1:0]            res_status,
    output logic [23:0]           res_computed_sum,
    output logic [29:0]           res_received_sum
);

    ctfc_pkg::phase_t phase_reg, phase_next;
    logic [23:0] payload_sum_reg,  payload_sum_next;
    logic [3:0]  digit_length_reg, digit_length_next;
    logic [29:0] value_accum_reg,  value_accum_next;
    logic [3:0]  digits_seen_reg,  digits_seen_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic [23:0] out_sum_reg, out_sum_next;
    logic [29:0] out_value_reg, out_value_next;

    logic        produces, take, out_free;
    logic [24:0] sum_add;
    logic [4:0]  len_add;
    logic [33:0] value_mul;
    logic [1:0]  status_now;

    // a result can go out when the output register is empty or draining
    assign out_free   = !out_valid_reg || res_ready;
    assign produces   = !item.start && (phase_reg == ctfc_pkg::PH_DIGITS) && item.hit_end;
    assign item_ready = !produces || out_free;
    assign take       = item_valid && item_ready;

    // arithmetic: saturating byte sum, length sum, times ten plus digit
    assign sum_add   = {1'b0, payload_sum_reg} + {17'd0, item.data};
    assign len_add   = {1'b0, digit_length_reg} + {1'b0, item.digit};
    assign value_mul = {1'b0, value_accum_reg, 3'b000} + {3'b000, value_accum_reg, 1'b0}
                     + {30'd0, item.digit};

    always_comb
    begin
        if (digits_seen_reg < digit_length_reg)
            status_now = ctfc_pkg::STATUS_SHORT;
        else if (value_accum_reg == {6'd0, payload_sum_reg})
            status_now = ctfc_pkg::STATUS_MATCH;
        else
            status_now = ctfc_pkg::STATUS_MISMATCH;
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            if (item.start)
                phase_next = ctfc_pkg::PH_PAYLOAD;
            else
            begin
                case (phase_reg)
                    ctfc_pkg::PH_IDLE:    phase_next = ctfc_pkg::PH_IDLE;
                    ctfc_pkg::PH_PAYLOAD:
                        if (item.hit_open)  phase_next = ctfc_pkg::PH_LENGTH;
                    ctfc_pkg::PH_LENGTH:
                        if (item.hit_close) phase_next = ctfc_pkg::PH_DIGITS;
                    ctfc_pkg::PH_DIGITS:
                        if (item.hit_end)   phase_next = ctfc_pkg::PH_IDLE;
                    default:              phase_next = ctfc_pkg::PH_IDLE;
                endcase
            end
        end
    end

    // accumulators per phase
    always_comb
    begin
        payload_sum_next  = payload_sum_reg;
        digit_length_next = digit_length_reg;
        value_accum_next  = value_accum_reg;
        digits_seen_next  = digits_seen_reg;
        if (take)
        begin
            if (item.start || produces)
            begin
                payload_sum_next  = '0;
                digit_length_next = '0;
                value_accum_next  = '0;
                digits_seen_next  = '0;
            end
            else
            begin
                case (phase_reg)
                    ctfc_pkg::PH_PAYLOAD:
                        if (!item.hit_open)
                            payload_sum_next = sum_add[24] ? ctfc_pkg::SUM_MAX
                                                           : sum_add[23:0];
                    ctfc_pkg::PH_LENGTH:
                        if (!item.hit_close && item.is_digit)
                            digit_length_next = len_add[4] ? ctfc_pkg::LEN_MAX
                                                           : len_add[3:0];
                    ctfc_pkg::PH_DIGITS:
                        if (item.is_digit && (digits_seen_reg < digit_length_reg))
                        begin
                            value_accum_next = (value_mul > {4'd0, ctfc_pkg::VALUE_MAX})
                                             ? ctfc_pkg::VALUE_MAX : value_mul[29:0];
                            digits_seen_next = digits_seen_reg + 1'b1;
                        end
                    default: ;
                endcase
            end
        end
    end

    // result register: load on end mark, drop when taken
    always_comb
    begin
        out_valid_next  = out_valid_reg && !res_ready;
        out_status_next = out_status_reg;
        out_sum_next    = out_sum_reg;
        out_value_next  = out_value_reg;
        if (take && produces)
        begin
            out_valid_next  = 1'b1;
            out_status_next = status_now;
            out_sum_next    = payload_sum_reg;
            out_value_next  = value_accum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= ctfc_pkg::PH_IDLE;
            payload_sum_reg  <= '0;
            digit_length_reg <= '0;
            value_accum_reg  <= '0;
            digits_seen_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            payload_sum_reg  <= payload_sum_next;
            digit_length_reg <= digit_length_next;
            value_accum_reg  <= value_accum_next;
            digits_seen_reg  <= digits_seen_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_sum_reg    <= out_sum_next;
        out_value_reg  <= out_value_next;
    end

    assign res_valid        = out_valid_reg;
    assign res_status       = out_status_reg;
    assign res_computed_sum = out_sum_reg;
    assign res_received_sum = out_value_reg;

    // checks
    `CTFC_ASSERT_IMP(a_seen_le_len, 1'b1, digits_seen_reg <= digit_length_reg, "digits seen beyond length")
    `CTFC_ASSERT_IMP(a_idle_clear, phase_reg == ctfc_pkg::PH_IDLE, payload_sum_reg == '0 && digits_seen_reg == '0, "idle with live state")
    `CTFC_ASSERT_IMP(a_no_overwrite, take && produces, out_free, "result register overwritten")
    `CTFC_ASSERT_NXT(a_result_on_end, take && produces, out_valid_reg && phase_reg == ctfc_pkg::PH_IDLE, "end mark gave no result")

endmodule

`default_nettype wire

// File: verif/tb_checksum_trailer_frame_checker.sv
// Testbench for the checksum trailer frame checker: directed table, long frame, random phases.
module tb_checksum_trailer_frame_checker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DECIMAL_BASE     = 10;
    localparam int PHASE_COUNT      = 8;
    localparam int PHASE_BYTES      = 180;
    localparam int LONG_FRAME_BYTES = 200;
    localparam int HOLD_CYCLES      = 300;
    localparam int SETTLE_CYCLES    = 8;
    localparam int MAX_GAP          = 20;
    localparam int CYCLE_LIMIT      = 600000;
    localparam int REPORT_LIMIT     = 100;

    // One frame result, laid out as on m_tdata
    typedef struct packed {
        logic [29:0] received;
        logic [23:0] computed;
        logic [1:0]  status;
    } frame_result_t;

    typedef struct packed {
        logic [7:0] b;
        logic       st;
    } stream_byte_t;

    typedef struct packed {
        logic [7:0]    b;
        logic          st;
        logic          typed;
        frame_result_t want;
    } directed_row_t;

    localparam frame_result_t NO_RESULT = '0;

    // Directed bytes under the reset marks; checked rows carry their result
    localparam directed_row_t DIRECTED_ROWS [32] = '{
        // byte while idle is dropped
        '{"A",   1'b0, 1'b0, NO_RESULT},
        // open mark first, length saturates, non-digit in length, value saturates
        '{8'h00, 1'b1, 1'b0, NO_RESULT},
        '{"(",   1'b0, 1'b0, NO_RESULT},
        '{"9",   1'b0, 1'b0, NO_RESULT},
        '{"7",   1'b0, 1'b0, NO_RESULT},
        '{"*",   1'b0, 1'b0, NO_RESULT},
        '{")",   1'b0, 1'b0, NO_RESULT},
        '{"9",   1'b0, 1'b0, NO_RESULT},
        '{"9",   1'b0, 1'b0, NO_RESULT},
        '{"9",   1'b0, 1'b0, NO_RESULT},
        '{"9",   1'b0, 1'b0, NO_RESULT},
        '{"9",   1'b0, 1'b0, NO_RESULT},
        '{"9",   1'b0, 1'b0, NO_RESULT},
        '{"9",   1'b0, 1'b0, NO_RESULT},
        '{"9",   1'b0, 1'b0, NO_RESULT},
        '{"9",   1'b0, 1'b0, NO_RESULT},
        '{"9",   1'b0, 1'b0, NO_RESULT},
        '{"*",   1'b0, 1'b1, '{ctfc_pkg::VALUE_MAX, 24'd0, ctfc_pkg::STATUS_SHORT}},
        // end mark summed in payload, zero length, digit past length dropped
        '{8'hFF, 1'b1, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{"*",   1'b0, 1'b0, NO_RESULT},
        '{"(",   1'b0, 1'b0, NO_RESULT},
        '{")",   1'b0, 1'b0, NO_RESULT},
        '{"7",   1'b0, 1'b0, NO_RESULT},
        '{"*",   1'b0, 1'b1, '{30'd0, 24'd297, ctfc_pkg::STATUS_MISMATCH}},
        // restart inside the length field, then an empty frame matches
        '{"5",   1'b1, 1'b0, NO_RESULT},
        '{"(",   1'b0, 1'b0, NO_RESULT},
        '{"1",   1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, 1'b0, NO_RESULT},
        '{"(",   1'b0, 1'b0, NO_RESULT},
        '{")",   1'b0, 1'b0, NO_RESULT},
        '{"*",   1'b0, 1'b1, '{30'd0, 24'd0, ctfc_pkg::STATUS_MATCH}}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;

    // Parser copy kept by the testbench
    ctfc_pkg::phase_t parse_phase;
    logic [23:0]      payload_total;
    logic [3:0]       length_total;
    logic [29:0]      trailer_value;
    logic [3:0]       trailer_digits;
    logic [7:0]       mark_open;
    logic [7:0]       mark_close;
    logic [7:0]       mark_end;

    frame_result_t pending_results [$];
    stream_byte_t  frame_bytes [$];

    int error_count  = 0;
    int cycle_count  = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit hold_req     = 1'b0;

    checksum_trailer_frame_checker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic void restart_parser();
        parse_phase    = ctfc_pkg::PH_IDLE;
        payload_total  = '0;
        length_total   = '0;
        trailer_value  = '0;
        trailer_digits = '0;
    endfunction

    // Advance the parser copy by one byte; returns 1 when the byte ends a frame
    function automatic bit advance_frame_parser(input logic [7:0] b, input logic st,
                                                output frame_result_t res);
        logic        digit_ok;
        logic [3:0]  digit_val;
        logic [24:0] sum_next;
        logic [4:0]  len_next;
        logic [33:0] value_next;
        digit_ok  = (b >= ctfc_pkg::DIGIT_ZERO) && (b <= ctfc_pkg::DIGIT_NINE);
        digit_val = digit_ok ? 4'(b - ctfc_pkg::DIGIT_ZERO) : 4'd0;
        res       = NO_RESULT;
        if (st)
        begin
            restart_parser();
            parse_phase = ctfc_pkg::PH_PAYLOAD;
            return 1'b0;
        end
        case (parse_phase)
            ctfc_pkg::PH_PAYLOAD:
            begin
                if (b == mark_open)
                    parse_phase = ctfc_pkg::PH_LENGTH;
                else
                begin
                    sum_next      = {1'b0, payload_total} + 25'(b);
                    payload_total = (sum_next > 25'(ctfc_pkg::SUM_MAX)) ? ctfc_pkg::SUM_MAX
                                                                        : sum_next[23:0];
                end
            end
            ctfc_pkg::PH_LENGTH:
            begin
                if (b == mark_close)
                    parse_phase = ctfc_pkg::PH_DIGITS;
                else if (digit_ok)
                begin
                    len_next     = {1'b0, length_total} + 5'(digit_val);
                    length_total = (len_next > 5'(ctfc_pkg::LEN_MAX)) ? ctfc_pkg::LEN_MAX
                                                                      : len_next[3:0];
                end
            end
            ctfc_pkg::PH_DIGITS:
            begin
                if (b == mark_end)
                begin
                    if (trailer_digits < length_total)
                        res.status = ctfc_pkg::STATUS_SHORT;
                    else if (trailer_value == 30'(payload_total))
                        res.status = ctfc_pkg::STATUS_MATCH;
                    else
                        res.status = ctfc_pkg::STATUS_MISMATCH;
                    res.computed = payload_total;
                    res.received = trailer_value;
                    restart_parser();
                    return 1'b1;
                end
                if (digit_ok && trailer_digits < length_total)
                begin
                    value_next     = 34'(trailer_value) * 34'(DECIMAL_BASE) + 34'(digit_val);
                    trailer_value  = (value_next > 34'(ctfc_pkg::VALUE_MAX))
                                   ? ctfc_pkg::VALUE_MAX : value_next[29:0];
                    trailer_digits = trailer_digits + 4'd1;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic void compare_field(input string field, input longint want,
                                          input longint got);
        if (want != got)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
        end
    endfunction

    function automatic void check_result(input frame_result_t got);
        frame_result_t want;
        if (pending_results.size() == 0)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("%0t ns: unexpected result, expected none, actual %0d/%0d/%0d",
                         $time, got.status, got.computed, got.received);
            return;
        end
        want = pending_results.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("computed_sum", want.computed, got.computed);
        compare_field("received_sum", want.received, got.received);
    endfunction

    // Offer one byte, wait for the transaction, then record what it should cause
    task automatic send_byte(input logic [7:0] b, input logic st, input logic typed,
                             input frame_result_t typed_res);
        int            gap;
        frame_result_t res;
        bit            produced;
        gap = 0;
        while (tx_idle_pct != 0 && gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= st;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        produced = advance_frame_parser(b, st, res);
        if (typed)
            pending_results.push_back(typed_res);
        else if (produced)
            pending_results.push_back(res);
    endtask

    // Stop sending until every result is back, then let trailing bytes settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mark(input logic [1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            ctfc_pkg::REG_OPEN_MARK:  mark_open  = val;
            ctfc_pkg::REG_CLOSE_MARK: mark_close = val;
            ctfc_pkg::REG_END_MARK:   mark_end   = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic logic [7:0] digit_char(input int d);
        return 8'(ctfc_pkg::DIGIT_ZERO + 8'(d));
    endfunction

    // Mostly well-formed frames with random content; some noise and broken frames
    task automatic build_frame();
        int         n_pay;
        int         pay_sum;
        int         mode;
        int         len;
        int         split;
        int         n_dig;
        string      txt;
        logic [7:0] b;
        frame_bytes.delete();
        if ($urandom_range(9) == 0)
            frame_bytes.push_back('{8'($urandom_range(255)), 1'b0});
        frame_bytes.push_back('{8'($urandom_range(255)), 1'b1});
        n_pay   = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(6);
        pay_sum = 0;
        repeat (n_pay)
        begin
            b = 8'($urandom_range(255));
            if (b == mark_open)
                b = b ^ 8'h01;
            pay_sum += b;
            frame_bytes.push_back('{b, 1'b0});
        end
        frame_bytes.push_back('{mark_open, 1'b0});

        // 0-4 match, 5-6 mismatch, 7 short, 8 extra digits, 9 zero length
        txt  = $sformatf("%0d", pay_sum);
        mode = $urandom_range(9);
        len  = (mode == 9) ? 0 : txt.len();

        // length field
        if ($urandom_range(4) == 0)
            frame_bytes.push_back('{8'($urandom_range(255)), 1'b0});
        if (len != 0 && $urandom_range(1) == 1)
        begin
            split = $urandom_range(len);
            frame_bytes.push_back('{digit_char(split), 1'b0});
            frame_bytes.push_back('{digit_char(len - split), 1'b0});
        end
        else if (len != 0 || $urandom_range(1) == 1)
            frame_bytes.push_back('{digit_char(len), 1'b0});
        frame_bytes.push_back('{mark_close, 1'b0});

        // checksum digits
        case (mode)
            5, 6:    n_dig = len;
            7:       n_dig = $urandom_range(len - 1);
            8:       n_dig = len + $urandom_range(3, 1);
            9:       n_dig = $urandom_range(2);
            default: n_dig = len;
        endcase
        for (int i = 0; i < n_dig; i++)
        begin
            if (mode <= 4 || ((mode == 7 || mode == 8) && i < txt.len()))
                b = 8'(txt.getc(i));
            else
                b = digit_char($urandom_range(9));
            frame_bytes.push_back('{b, 1'b0});
            if ($urandom_range(19) == 0)
                frame_bytes.push_back('{8'($urandom_range(255)), 1'b0});
        end

        // a few frames break off or restart before their end mark
        case ($urandom_range(39))
            0:       ;
            1:       frame_bytes.push_back('{8'($urandom_range(255)), 1'b1});
            default: frame_bytes.push_back('{mark_end, 1'b0});
        endcase
    endtask

    // Result side: check each transaction, then choose the next ready
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                check_result(frame_result_t'(m_tdata));
            if (hold_req && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Stimulus
    initial
    begin
        int         phase_bytes;
        logic [7:0] marks [3];
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= ctfc_pkg::REG_OPEN_MARK;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        restart_parser();
        mark_open  = ctfc_pkg::OPEN_MARK_RST;
        mark_close = ctfc_pkg::CLOSE_MARK_RST;
        mark_end   = ctfc_pkg::END_MARK_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table under the reset marks
        foreach (DIRECTED_ROWS[i])
            send_byte(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].st, DIRECTED_ROWS[i].typed,
                      DIRECTED_ROWS[i].want);
        drain_results();

        // long payload of full bytes with an empty trailer
        send_byte(8'h00, 1'b1, 1'b0, NO_RESULT);
        repeat (LONG_FRAME_BYTES) send_byte(8'hFF, 1'b0, 1'b0, NO_RESULT);
        send_byte(mark_open, 1'b0, 1'b0, NO_RESULT);
        send_byte(mark_close, 1'b0, 1'b0, NO_RESULT);
        send_byte(mark_end, 1'b0, 1'b0, NO_RESULT);
        drain_results();

        // random phases, each writing its marks and setting its idle pattern
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 61; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 61; end
                default: begin tx_idle_pct = 25; rx_stall_pct = 25; end
            endcase
            case (p)
                0:       marks = '{ctfc_pkg::OPEN_MARK_RST, ctfc_pkg::CLOSE_MARK_RST,
                                   ctfc_pkg::END_MARK_RST};
                1:       marks = '{8'h00, 8'hFF, 8'h80};
                2:       marks = '{8'hFF, 8'h00, 8'h7F};
                3:       marks = '{"5", "5", "5"};
                4:       marks = '{"0", "9", "#"};
                default: marks = '{8'($urandom_range(255)), 8'($urandom_range(255)),
                                   8'($urandom_range(255))};
            endcase
            write_mark(ctfc_pkg::REG_OPEN_MARK, marks[0]);
            write_mark(ctfc_pkg::REG_CLOSE_MARK, marks[1]);
            write_mark(ctfc_pkg::REG_END_MARK, marks[2]);

            // long receiver hold-off while frames keep coming
            if (p == 0)
                hold_req = 1'b1;

            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                build_frame();
                foreach (frame_bytes[j])
                    send_byte(frame_bytes[j].b, frame_bytes[j].st, 1'b0, NO_RESULT);
                phase_bytes += frame_bytes.size();
            end
            drain_results();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
